// ----- design/h2r_pkg.sv -----
// Shared constants, codes and types of the HSV to RGB converter.
`default_nettype none

package h2r_pkg;

  localparam int CHANNEL_BITS_DEF = 8;

  localparam int HUE_W  = 16;
  localparam int REM_W  = 12;
  localparam int SEXT_W = 5;

  localparam int LANES  = 3;
  localparam int LANE_P = 0;
  localparam int LANE_Q = 1;
  localparam int LANE_T = 2;

  localparam logic [HUE_W-1:0] HUE_FULL_TURN = 16'd23040;
  localparam logic [REM_W-1:0] HUE_SEXTANT   = 12'd3840;

  // A sextant is 15 << 8 hue units. For an 8-bit x, x / 15 = ((x + 1) * 273) >> 12.
  localparam int         FRAC_SHIFT  = 8;
  localparam logic [8:0] RECIP_15    = 9'd273;
  localparam int         RECIP_SHIFT = 12;

  localparam logic [SEXT_W-1:0] SX_RED     = 5'd0;
  localparam logic [SEXT_W-1:0] SX_YELLOW  = 5'd1;
  localparam logic [SEXT_W-1:0] SX_GREEN   = 5'd2;
  localparam logic [SEXT_W-1:0] SX_CYAN    = 5'd3;
  localparam logic [SEXT_W-1:0] SX_BLUE    = 5'd4;
  localparam logic [SEXT_W-1:0] SX_MAGENTA = 5'd5;

  typedef struct packed {
    logic              grey;
    logic [SEXT_W-1:0] sext;
  } h2r_side_t;

endpackage

`default_nettype wire

// ----- design/h2r_intf.sv -----
// Request channel interfaces for HSV pixels in and RGB pixels out.
`default_nettype none

interface h2r_in_if #(
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF
) ();
  import h2r_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [HUE_W-1:0]        hue_deg_x64;
  logic [CHANNEL_BITS-1:0] sat_code;
  logic [CHANNEL_BITS-1:0] val_code;

  modport source (output valid, output hue_deg_x64, output sat_code, output val_code,
                  input ready);
  modport sink (input valid, input hue_deg_x64, input sat_code, input val_code,
                output ready);
endinterface

interface h2r_out_if #(
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- design/h2r_sextant.sv -----
// Hue split into sextant and remainder, two pipeline stages.
`default_nettype none

module h2r_sextant #(
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [h2r_pkg::HUE_W-1:0] in_hue,
  input  logic [CHANNEL_BITS-1:0]   in_sat,
  input  logic [CHANNEL_BITS-1:0]   in_val,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [h2r_pkg::REM_W-1:0] out_rem,
  output logic [CHANNEL_BITS-1:0]   out_sat,
  output logic [CHANNEL_BITS-1:0]   out_val,
  output h2r_pkg::h2r_side_t        out_side
);
  import h2r_pkg::*;

  logic                    s1_vld_r;
  logic [HUE_W-1:0]        s1_hue_r;
  logic [CHANNEL_BITS-1:0] s1_sat_r;
  logic [CHANNEL_BITS-1:0] s1_val_r;
  h2r_side_t               s1_side_r;

  logic                    s2_vld_r;
  logic [REM_W-1:0]        s2_rem_r;
  logic [CHANNEL_BITS-1:0] s2_sat_r;
  logic [CHANNEL_BITS-1:0] s2_val_r;
  h2r_side_t               s2_side_r;

  logic             s1_rdy;
  logic             s2_rdy;
  logic [HUE_W-1:0] hue_norm;
  logic [8:0]       hue_hi_inc;
  logic [17:0]      sext_prod;
  h2r_side_t        s1_side_nxt;
  logic [8:0]       sext_x15;
  logic [16:0]      hue_base;
  logic [16:0]      rem_full;
  logic [REM_W-1:0] s2_rem_nxt;

  assign s2_rdy   = !s2_vld_r || out_ready;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_comb begin
    hue_norm         = (in_hue == HUE_FULL_TURN) ? '0 : in_hue;
    hue_hi_inc       = {1'b0, hue_norm[HUE_W-1:FRAC_SHIFT]} + 9'd1;
    sext_prod        = {9'd0, hue_hi_inc} * {9'd0, RECIP_15};
    s1_side_nxt.sext = sext_prod[RECIP_SHIFT +: SEXT_W];
    s1_side_nxt.grey = (in_sat == '0);
  end

  always_comb begin
    sext_x15   = {s1_side_r.sext, 4'b0000} - {4'b0000, s1_side_r.sext};
    hue_base   = {sext_x15, {FRAC_SHIFT{1'b0}}};
    rem_full   = {1'b0, s1_hue_r} - hue_base;
    s2_rem_nxt = rem_full[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_hue_r  <= hue_norm;
      s1_sat_r  <= in_sat;
      s1_val_r  <= in_val;
      s1_side_r <= s1_side_nxt;
    end
    if (s2_rdy && s1_vld_r) begin
      s2_rem_r  <= s2_rem_nxt;
      s2_sat_r  <= s1_sat_r;
      s2_val_r  <= s1_val_r;
      s2_side_r <= s1_side_r;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_rem   = s2_rem_r;
  assign out_sat   = s2_sat_r;
  assign out_val   = s2_val_r;
  assign out_side  = s2_side_r;

endmodule

`default_nettype wire

// ----- design/h2r_terms.sv -----
// Numerators of the p, q and t terms, three pipeline stages.
`default_nettype none

module h2r_terms #(
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF,
  localparam int Y_W = 2 * CHANNEL_BITS + 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [h2r_pkg::REM_W-1:0]              in_rem,
  input  logic [CHANNEL_BITS-1:0]                in_sat,
  input  logic [CHANNEL_BITS-1:0]                in_val,
  input  h2r_pkg::h2r_side_t                     in_side,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [h2r_pkg::LANES-1:0][Y_W-1:0]     out_y,
  output logic [CHANNEL_BITS-1:0]                out_val,
  output h2r_pkg::h2r_side_t                     out_side
);
  import h2r_pkg::*;

  localparam int N_W = CHANNEL_BITS + REM_W;
  localparam int P_W = CHANNEL_BITS + N_W;
  localparam logic [N_W-1:0] DEN = N_W'(((1 << CHANNEL_BITS) - 1) * 3840);

  logic                        s3_vld_r;
  logic [LANES-1:0][N_W-1:0]   s3_sk_r;
  logic [CHANNEL_BITS-1:0]     s3_val_r;
  h2r_side_t                   s3_side_r;

  logic                        s4_vld_r;
  logic [LANES-1:0][N_W-1:0]   s4_num_r;
  logic [CHANNEL_BITS-1:0]     s4_val_r;
  h2r_side_t                   s4_side_r;

  logic                        s5_vld_r;
  logic [LANES-1:0][Y_W-1:0]   s5_y_r;
  logic [CHANNEL_BITS-1:0]     s5_val_r;
  h2r_side_t                   s5_side_r;

  logic                        s3_rdy;
  logic                        s4_rdy;
  logic                        s5_rdy;
  logic [LANES-1:0][REM_W-1:0] frac_k;
  logic [LANES-1:0][N_W-1:0]   s3_sk_nxt;
  logic [LANES-1:0][N_W-1:0]   s4_num_nxt;
  logic [LANES-1:0][P_W-1:0]   prod;
  logic [LANES-1:0][Y_W-1:0]   s5_y_nxt;

  assign s5_rdy   = !s5_vld_r || out_ready;
  assign s4_rdy   = !s4_vld_r || s5_rdy;
  assign s3_rdy   = !s3_vld_r || s4_rdy;
  assign in_ready = s3_rdy;

  // Each term is v * (FULL * 3840 - s * k) / (FULL * 3840) for its own k.
  always_comb begin
    frac_k[LANE_P] = HUE_SEXTANT;
    frac_k[LANE_Q] = in_rem;
    frac_k[LANE_T] = HUE_SEXTANT - in_rem;
    for (int l = 0; l < LANES; l++) begin
      s3_sk_nxt[l]  = {{REM_W{1'b0}}, in_sat} * {{CHANNEL_BITS{1'b0}}, frac_k[l]};
      s4_num_nxt[l] = DEN - s3_sk_r[l];
      prod[l]       = {{N_W{1'b0}}, s4_val_r} * {{CHANNEL_BITS{1'b0}}, s4_num_r[l]};
      s5_y_nxt[l]   = prod[l][P_W-1:FRAC_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (s3_rdy) begin
        s3_vld_r <= in_valid;
      end
      if (s4_rdy) begin
        s4_vld_r <= s3_vld_r;
      end
      if (s5_rdy) begin
        s5_vld_r <= s4_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && in_valid) begin
      s3_sk_r   <= s3_sk_nxt;
      s3_val_r  <= in_val;
      s3_side_r <= in_side;
    end
    if (s4_rdy && s3_vld_r) begin
      s4_num_r  <= s4_num_nxt;
      s4_val_r  <= s3_val_r;
      s4_side_r <= s3_side_r;
    end
    if (s5_rdy && s4_vld_r) begin
      s5_y_r    <= s5_y_nxt;
      s5_val_r  <= s4_val_r;
      s5_side_r <= s4_side_r;
    end
  end

  assign out_valid = s5_vld_r;
  assign out_y     = s5_y_r;
  assign out_val   = s5_val_r;
  assign out_side  = s5_side_r;

endmodule

`default_nettype wire

// ----- design/h2r_div.sv -----
// Division of the three term products by 15 * FULL, three pipeline stages, three lanes.
`default_nettype none

module h2r_div #(
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF,
  localparam int Y_W = 2 * CHANNEL_BITS + 4
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [h2r_pkg::LANES-1:0][Y_W-1:0]          in_y,
  input  logic [CHANNEL_BITS-1:0]                     in_val,
  input  h2r_pkg::h2r_side_t                          in_side,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [h2r_pkg::LANES-1:0][CHANNEL_BITS-1:0] out_quo,
  output logic [CHANNEL_BITS-1:0]                     out_val,
  output h2r_pkg::h2r_side_t                          out_side
);
  import h2r_pkg::*;

  localparam int C   = CHANNEL_BITS;
  localparam int M_W = C + 1;
  localparam int E_W = Y_W + M_W;
  localparam logic [Y_W-1:0] DIVISOR = Y_W'(15 * ((1 << C) - 1));
  localparam logic [M_W-1:0] RECIP   =
    M_W'((64'd1 << Y_W) / (64'd15 * ((64'd1 << C) - 64'd1)));

  logic                        s6_vld_r;
  logic [LANES-1:0][Y_W-1:0]   s6_y_r;
  logic [LANES-1:0][C-1:0]     s6_quo_r;
  logic [C-1:0]                s6_val_r;
  h2r_side_t                   s6_side_r;

  logic                        s7_vld_r;
  logic [LANES-1:0][Y_W-1:0]   s7_rem_r;
  logic [LANES-1:0][C-1:0]     s7_quo_r;
  logic [C-1:0]                s7_val_r;
  h2r_side_t                   s7_side_r;

  logic                        s8_vld_r;
  logic [LANES-1:0][C-1:0]     s8_quo_r;
  logic [C-1:0]                s8_val_r;
  h2r_side_t                   s8_side_r;

  logic                        s6_rdy;
  logic                        s7_rdy;
  logic                        s8_rdy;
  logic [LANES-1:0][E_W-1:0]   est_prod;
  logic [LANES-1:0][C-1:0]     s6_quo_nxt;
  logic [LANES-1:0][Y_W-1:0]   qd_prod;
  logic [LANES-1:0][Y_W-1:0]   s7_rem_nxt;
  logic [LANES-1:0][C-1:0]     s8_quo_nxt;

  assign s8_rdy   = !s8_vld_r || out_ready;
  assign s7_rdy   = !s7_vld_r || s8_rdy;
  assign s6_rdy   = !s6_vld_r || s7_rdy;
  assign in_ready = s6_rdy;

  // The reciprocal estimate is low by at most one, so one compare against the divisor
  // corrects it.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      est_prod[l]   = {{M_W{1'b0}}, in_y[l]} * {{Y_W{1'b0}}, RECIP};
      s6_quo_nxt[l] = est_prod[l][Y_W +: C];
      qd_prod[l]    = {{(Y_W-C){1'b0}}, s6_quo_r[l]} * DIVISOR;
      s7_rem_nxt[l] = s6_y_r[l] - qd_prod[l];
      s8_quo_nxt[l] = s7_quo_r[l] + {{(C-1){1'b0}}, (s7_rem_r[l] >= DIVISOR)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
    end else begin
      if (s6_rdy) begin
        s6_vld_r <= in_valid;
      end
      if (s7_rdy) begin
        s7_vld_r <= s6_vld_r;
      end
      if (s8_rdy) begin
        s8_vld_r <= s7_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s6_rdy && in_valid) begin
      s6_y_r    <= in_y;
      s6_quo_r  <= s6_quo_nxt;
      s6_val_r  <= in_val;
      s6_side_r <= in_side;
    end
    if (s7_rdy && s6_vld_r) begin
      s7_rem_r  <= s7_rem_nxt;
      s7_quo_r  <= s6_quo_r;
      s7_val_r  <= s6_val_r;
      s7_side_r <= s6_side_r;
    end
    if (s8_rdy && s7_vld_r) begin
      s8_quo_r  <= s8_quo_nxt;
      s8_val_r  <= s7_val_r;
      s8_side_r <= s7_side_r;
    end
  end

  assign out_valid = s8_vld_r;
  assign out_quo   = s8_quo_r;
  assign out_val   = s8_val_r;
  assign out_side  = s8_side_r;

endmodule

`default_nettype wire

// ----- design/hsv_to_rgb_converter_core.sv -----
// Top level of the HSV to RGB pixel converter with sextant routing and output register.
`default_nettype none

// Converts one HSV pixel per clock to RGB. Hue is in 1/64 degree units, with 360 degrees
// folded to 0 and hue above 360 degrees giving black unless saturation is zero, which
// gives grey at the value code. On its way to the result a pixel passes these steps: two
// stages split the hue into sextant and remainder, three form the p, q and t numerators,
// three divide them by 15 * (2^CHANNEL_BITS - 1) through a reciprocal estimate and one
// correction step, and the output register routes the terms. A new request is taken every
// cycle; stalls on the result side fill pipeline bubbles before they hold off the input.
module hsv_to_rgb_converter_core #(
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  h2r_in_if.sink    in_ch,
  h2r_out_if.source out_ch
);
  import h2r_pkg::*;

  localparam int Y_W = 2 * CHANNEL_BITS + 4;

  logic                              sx_valid;
  logic                              sx_ready;
  logic [REM_W-1:0]                  sx_rem;
  logic [CHANNEL_BITS-1:0]           sx_sat;
  logic [CHANNEL_BITS-1:0]           sx_val;
  h2r_side_t                         sx_side;

  logic                              tm_valid;
  logic                              tm_ready;
  logic [LANES-1:0][Y_W-1:0]         tm_y;
  logic [CHANNEL_BITS-1:0]           tm_val;
  h2r_side_t                         tm_side;

  logic                              dv_valid;
  logic                              dv_ready;
  logic [LANES-1:0][CHANNEL_BITS-1:0] dv_quo;
  logic [CHANNEL_BITS-1:0]           dv_val;
  h2r_side_t                         dv_side;

  logic                              out_vld_r;
  logic [CHANNEL_BITS-1:0]           out_red_r;
  logic [CHANNEL_BITS-1:0]           out_green_r;
  logic [CHANNEL_BITS-1:0]           out_blue_r;
  logic [CHANNEL_BITS-1:0]           out_red_nxt;
  logic [CHANNEL_BITS-1:0]           out_green_nxt;
  logic [CHANNEL_BITS-1:0]           out_blue_nxt;
  logic [CHANNEL_BITS-1:0]           term_p;
  logic [CHANNEL_BITS-1:0]           term_q;
  logic [CHANNEL_BITS-1:0]           term_t;
  logic                              out_load;

  h2r_sextant #(.CHANNEL_BITS(CHANNEL_BITS)) u_sextant (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_hue    (in_ch.hue_deg_x64),
    .in_sat    (in_ch.sat_code),
    .in_val    (in_ch.val_code),
    .out_valid (sx_valid),
    .out_ready (sx_ready),
    .out_rem   (sx_rem),
    .out_sat   (sx_sat),
    .out_val   (sx_val),
    .out_side  (sx_side)
  );

  h2r_terms #(.CHANNEL_BITS(CHANNEL_BITS)) u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sx_valid),
    .in_ready  (sx_ready),
    .in_rem    (sx_rem),
    .in_sat    (sx_sat),
    .in_val    (sx_val),
    .in_side   (sx_side),
    .out_valid (tm_valid),
    .out_ready (tm_ready),
    .out_y     (tm_y),
    .out_val   (tm_val),
    .out_side  (tm_side)
  );

  h2r_div #(.CHANNEL_BITS(CHANNEL_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tm_valid),
    .in_ready  (tm_ready),
    .in_y      (tm_y),
    .in_val    (tm_val),
    .in_side   (tm_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_quo   (dv_quo),
    .out_val   (dv_val),
    .out_side  (dv_side)
  );

  assign dv_ready = !out_vld_r || out_ch.ready;
  assign out_load = dv_valid && dv_ready;

  assign term_p = dv_quo[LANE_P];
  assign term_q = dv_quo[LANE_Q];
  assign term_t = dv_quo[LANE_T];

  always_comb begin
    out_red_nxt   = '0;
    out_green_nxt = '0;
    out_blue_nxt  = '0;
    if (dv_side.grey) begin
      out_red_nxt   = dv_val;
      out_green_nxt = dv_val;
      out_blue_nxt  = dv_val;
    end else begin
      case (dv_side.sext)
        SX_RED: begin
          out_red_nxt   = dv_val;
          out_green_nxt = term_t;
          out_blue_nxt  = term_p;
        end
        SX_YELLOW: begin
          out_red_nxt   = term_q;
          out_green_nxt = dv_val;
          out_blue_nxt  = term_p;
        end
        SX_GREEN: begin
          out_red_nxt   = term_p;
          out_green_nxt = dv_val;
          out_blue_nxt  = term_t;
        end
        SX_CYAN: begin
          out_red_nxt   = term_p;
          out_green_nxt = term_q;
          out_blue_nxt  = dv_val;
        end
        SX_BLUE: begin
          out_red_nxt   = term_t;
          out_green_nxt = term_p;
          out_blue_nxt  = dv_val;
        end
        SX_MAGENTA: begin
          out_red_nxt   = dv_val;
          out_green_nxt = term_p;
          out_blue_nxt  = term_q;
        end
        default: begin
          out_red_nxt   = '0;
          out_green_nxt = '0;
          out_blue_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (dv_ready) begin
      out_vld_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.red   = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue  = out_blue_r;

  a_rem_in_sextant: assert property (@(posedge clk) disable iff (!rst_n)
    sx_valid |-> (sx_rem < HUE_SEXTANT))
    else $error("hue remainder is not below one sextant");

  a_terms_below_value: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid |-> (term_p <= dv_val && term_q <= dv_val && term_t <= dv_val))
    else $error("divided term exceeds the value code");

  a_grey_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && dv_side.grey) |=>
      (out_ch.red == out_ch.green && out_ch.green == out_ch.blue))
    else $error("zero saturation did not give a grey pixel");

  a_black_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !dv_side.grey && dv_side.sext > SX_MAGENTA) |=>
      (out_ch.red == '0 && out_ch.green == '0 && out_ch.blue == '0))
    else $error("hue above a full turn did not give black");

endmodule

`default_nettype wire
